// ===== design/bpvbt_pkg.sv =====
// shared types, codes and trim arithmetic for the breath phase valve and blower trim block
`default_nettype none
package bpvbt_pkg;

	localparam int unsigned SETTING_W = 16;
	localparam int unsigned FLOW_W    = 21;
	localparam int unsigned PRESS_W   = 16;
	localparam int unsigned REG_IDX_W = 2;
	localparam int unsigned IN_DATA_W = 72;
	localparam int unsigned IN_USER_W = 5;

	typedef enum logic [2:0] {
		CMD_SAVE_VALVE = 3'd0,
		CMD_TRIM_VALVE = 3'd1,
		CMD_SAVE_SPEED = 3'd2,
		CMD_TRIM_SPEED = 3'd3,
		CMD_PRELOAD    = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		PH_NONE    = 2'd0,
		PH_EXP     = 2'd1,
		PH_INSP    = 2'd2,
		PH_PLATEAU = 2'd3
	} phase_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_VALVE_MIN = 2'd0,
		REG_VALVE_MAX = 2'd1,
		REG_SPEED_MIN = 2'd2,
		REG_SPEED_MAX = 2'd3
	} reg_idx_t;

	typedef logic signed [FLOW_W-1:0]  flow_t;
	typedef logic signed [PRESS_W-1:0] press_t;
	typedef logic [SETTING_W-1:0]      setting_t;

	// one saved phase slot
	typedef struct packed {
		flow_t    flow;
		setting_t valve;
		press_t   press;
		setting_t speed;
	} slot_t;

	typedef struct packed {
		setting_t valve_min;
		setting_t valve_max;
		setting_t speed_min;
		setting_t speed_max;
	} limits_t;

	// valve step from flow error; quotient by 1000 found by range compares
	function automatic logic signed [4:0] valve_step(input logic signed [FLOW_W:0] diff);
		logic [FLOW_W:0] mag;
		logic            pos;
		logic signed [4:0] step;
		mag = diff[FLOW_W] ? (FLOW_W+1)'(-diff) : diff;
		pos = !diff[FLOW_W];
		if (mag < 22'd1000)
			step = 5'sd0;
		else if (mag < 22'd2000)
			step = pos ? -5'sd3 : 5'sd2;
		else if (mag < 22'd3000)
			step = pos ? -5'sd5 : 5'sd3;
		else if (mag >= 22'd4000 && mag < 22'd5000)
			step = pos ? -5'sd7 : 5'sd3;
		else if (mag >= 22'd8000 && mag < 22'd9000)
			step = pos ? -5'sd11 : 5'sd5;
		else
			step = pos ? -5'sd13 : 5'sd5;
		return step;
	endfunction

	// banded speed change from pressure error
	function automatic logic signed [9:0] speed_delta(input logic signed [PRESS_W:0] diff);
		logic [PRESS_W:0]  mag;
		logic signed [9:0] d;
		logic signed [9:0] delta;
		mag = diff[PRESS_W] ? (PRESS_W+1)'(-diff) : diff;
		d   = diff[9:0];
		if (mag < 17'd20)
			delta = 10'sd0;
		else if (mag < 17'd30)
			delta = d * 10'sd3;
		else if (mag < 17'd40)
			delta = d * 10'sd10;
		else if (diff[PRESS_W])
			delta = -10'sd500;
		else
			delta = 10'sd500;
		return delta;
	endfunction

	// low limit first, then high limit
	function automatic setting_t clamp_to(input logic signed [17:0] v,
		input setting_t lo, input setting_t hi);
		logic signed [17:0] t;
		t = v;
		if (t < $signed({2'b00, lo}))
			t = $signed({2'b00, lo});
		if (t > $signed({2'b00, hi}))
			t = $signed({2'b00, hi});
		return t[SETTING_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/bpvbt_trim.sv =====
// trimmed valve setting or blower speed for one command
`default_nettype none
module bpvbt_trim import bpvbt_pkg::*; (
	input  wire cmd_t     cmd,
	input  wire phase_t   phase,
	input  wire flow_t    goal_flow,
	input  wire press_t   goal_press,
	input  wire slot_t    exp_slot,
	input  wire slot_t    insp_slot,
	input  wire limits_t  limits,
	output setting_t      result_value
);

	slot_t                   slot;
	logic signed [FLOW_W:0]  flow_err;
	logic signed [PRESS_W:0] press_err;
	logic signed [4:0]       vstep;
	logic signed [9:0]       sdelta;
	logic signed [17:0]      valve_sum;
	logic signed [17:0]      speed_sum;

	// plateau shares the inspiration slot
	assign slot = (phase == PH_EXP) ? exp_slot : insp_slot;

	assign flow_err  = {goal_flow[FLOW_W-1], goal_flow} - {slot.flow[FLOW_W-1], slot.flow};
	assign press_err = {goal_press[PRESS_W-1], goal_press}
		- {slot.press[PRESS_W-1], slot.press};

	assign vstep  = valve_step(flow_err);
	assign sdelta = speed_delta(press_err);

	assign valve_sum = $signed({2'b00, slot.valve}) + $signed({{13{vstep[4]}}, vstep});
	assign speed_sum = $signed({2'b00, slot.speed}) + $signed({{8{sdelta[9]}}, sdelta});

	always_comb begin
		case (cmd)
			CMD_TRIM_VALVE: begin
				if (phase == PH_NONE)
					result_value = exp_slot.valve;
				else
					result_value = clamp_to(valve_sum, limits.valve_min, limits.valve_max);
			end
			CMD_TRIM_SPEED: begin
				if (phase == PH_NONE)
					result_value = exp_slot.speed;
				else
					result_value = clamp_to(speed_sum, limits.speed_min, limits.speed_max);
			end
			default: result_value = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/breath_phase_valve_blower_trim.sv =====
// top level: command register, phase slots, limit registers and result register
// an input request is held in stage 1, then moves into the result register once that is free
// throughput: one command per cycle while the result side is not stalled, set by the single pass through the trim logic
// output register decouples the sides, so a new request is taken while a result waits if stage 1 is empty
// reset: arst_n clears both slots, the valid flags and sets limits to full range
`default_nettype none
module breath_phase_valve_blower_trim import bpvbt_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	// input request
	input  wire                    s_tvalid,
	output logic                   s_tready,
	// setting_value[15:0], flow_value[36:16], press_value[52:37], peak_press[68:53], zero pad
	input  wire [IN_DATA_W-1:0]    s_tdata,
	// cmd[2:0], phase[4:3]
	input  wire [IN_USER_W-1:0]    s_tuser,
	// result request
	output logic                   m_tvalid,
	input  wire                    m_tready,
	// result_value[15:0]
	output logic [SETTING_W-1:0]   m_tdata,
	// data_ready[0]
	output logic                   m_tuser,
	// limit register writes
	input  wire                    cfg_we,
	input  wire [REG_IDX_W-1:0]    cfg_addr,
	input  wire [SETTING_W-1:0]    cfg_wdata
);

	// stage 1: registered command
	logic     valid_s1;
	cmd_t     cmd_s1;
	phase_t   phase_s1;
	setting_t setting_s1;
	flow_t    flow_s1;
	press_t   press_s1;
	press_t   peak_s1;

	// saved phase data and limits
	slot_t    exp_q, insp_q;
	slot_t    exp_nxt, insp_nxt;
	limits_t  limits_q;

	// result register
	logic     out_valid_q;
	setting_t result_q;
	logic     data_ready_q;

	logic     advance;
	setting_t trim_result;

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;
	assign m_tuser  = data_ready_q;

	// input capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1     <= cmd_t'(s_tuser[2:0]);
			phase_s1   <= phase_t'(s_tuser[4:3]);
			setting_s1 <= s_tdata[15:0];
			flow_s1    <= s_tdata[36:16];
			press_s1   <= s_tdata[52:37];
			peak_s1    <= s_tdata[68:53];
		end
	end

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.valve_min <= '0;
			limits_q.valve_max <= '1;
			limits_q.speed_min <= '0;
			limits_q.speed_max <= '1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_VALVE_MIN: limits_q.valve_min <= cfg_wdata;
				REG_VALVE_MAX: limits_q.valve_max <= cfg_wdata;
				REG_SPEED_MIN: limits_q.speed_min <= cfg_wdata;
				REG_SPEED_MAX: limits_q.speed_max <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// trim reads the slots as they were before this command
	bpvbt_trim u_trim (
		.cmd          (cmd_s1),
		.phase        (phase_s1),
		.goal_flow    (flow_s1),
		.goal_press   (press_s1),
		.exp_slot     (exp_q),
		.insp_slot    (insp_q),
		.limits       (limits_q),
		.result_value (trim_result)
	);

	// slot updates; saves in phase none store nothing, plateau writes the inspiration slot
	always_comb begin
		exp_nxt  = exp_q;
		insp_nxt = insp_q;
		case (cmd_s1)
			CMD_SAVE_VALVE: begin
				if (phase_s1 == PH_EXP) begin
					exp_nxt.valve = setting_s1;
					exp_nxt.flow  = flow_s1;
				end else if (phase_s1 == PH_INSP || phase_s1 == PH_PLATEAU) begin
					insp_nxt.valve = setting_s1;
					insp_nxt.flow  = flow_s1;
				end
			end
			CMD_SAVE_SPEED: begin
				if (phase_s1 == PH_EXP) begin
					exp_nxt.speed = setting_s1;
					exp_nxt.press = press_s1;
				end else if (phase_s1 == PH_INSP || phase_s1 == PH_PLATEAU) begin
					insp_nxt.speed = setting_s1;
					insp_nxt.press = press_s1;
				end
			end
			CMD_PRELOAD: begin
				exp_nxt.press  = press_s1;
				insp_nxt.press = peak_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= '0;
			insp_q <= '0;
		end else if (advance) begin
			exp_q  <= exp_nxt;
			insp_q <= insp_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// data ready looks at the slot after this command's update
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q     <= trim_result;
			data_ready_q <= (exp_nxt.press != '0) && (exp_nxt.flow != '0);
		end
	end

endmodule
`default_nettype wire

// ===== design/bpvbt_checker.sv =====
// port level checks for the trim block, bound to the top level
`default_nettype none
module bpvbt_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [15:0] m_tdata,
	input wire        m_tuser
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// input side only stalls behind a stalled full output
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// an accepted request reaches the output once the output side is free
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
		else $error("accepted request did not produce a result");

endmodule

bind breath_phase_valve_blower_trim bpvbt_checker u_checker (.*);
`default_nettype wire

// ===== tb/tb_breath_phase_valve_blower_trim.sv =====
// self-checking testbench for the breath phase valve and blower trim block
module tb_breath_phase_valve_blower_trim;
	import bpvbt_pkg::*;

	// command codes the block must ignore
	localparam logic [2:0] CMD_SPARE_A = 3'd5;
	localparam logic [2:0] CMD_SPARE_B = 3'd6;
	localparam logic [2:0] CMD_SPARE_C = 3'd7;

	localparam int RAND_PER_SETTING = 165;
	localparam int STALL_LIMIT      = 2000;
	localparam int HOLD_AT_RESULT   = 300;
	localparam int HOLD_CYCLES      = 120;

	// one command request as the sender sees it
	typedef struct packed {
		logic [2:0] cmd;
		phase_t     phase;
		setting_t   setting;
		flow_t      flow;
		press_t     press;
		press_t     peak;
	} vent_cmd_t;

	// one trim result as the receiver sees it
	typedef struct packed {
		setting_t value;
		logic     ready;
	} trim_result_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     s_tvalid  = 1'b0;
	wire      s_tready;
	// setting_value, flow_value, press_value, peak_press, zero pad
	logic [IN_DATA_W-1:0] s_tdata = '0;
	// cmd, phase
	logic [IN_USER_W-1:0] s_tuser = '0;
	wire      m_tvalid;
	logic     m_tready  = 1'b0;
	// result_value
	wire [SETTING_W-1:0] m_tdata;
	// data_ready
	wire      m_tuser;
	logic     cfg_we    = 1'b0;
	reg_idx_t cfg_addr  = REG_VALVE_MIN;
	setting_t cfg_wdata = '0;

	breath_phase_valve_blower_trim dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// predictor copy of the limit registers
	setting_t lim_valve_min = 16'd0;
	setting_t lim_valve_max = 16'hFFFF;
	setting_t lim_speed_min = 16'd0;
	setting_t lim_speed_max = 16'hFFFF;

	// predictor copy of the phase slots, index 0 expiration, 1 inspiration and plateau
	flow_t    saved_flow  [2] = '{default: '0};
	setting_t saved_valve [2] = '{default: '0};
	press_t   saved_press [2] = '{default: '0};
	setting_t saved_speed [2] = '{default: '0};

	// what the stimulus generator expects the slots to hold, to aim targets near them
	int plan_flow  [2] = '{default: 0};
	int plan_press [2] = '{default: 0};

	vent_cmd_t    cmd_backlog [$];
	trim_result_t pending_trims [$];
	vent_cmd_t    offered;

	int cmds_taken    = 0;
	int results_taken = 0;
	int hold_left     = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	// saturate a signed trim value, low limit first
	function automatic setting_t limit_to(input int v, input int lo, input int hi);
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return setting_t'(v);
	endfunction

	// apply one command to the slots and work out the result it gives
	function automatic trim_result_t apply_command(input vent_cmd_t c);
		trim_result_t r;
		int s, err, quo, amag, v;
		r.value = '0;
		s = (c.phase == PH_EXP) ? 0 : 1;
		case (c.cmd)
			CMD_SAVE_VALVE: begin
				if (c.phase != PH_NONE) begin
					saved_valve[s] = c.setting;
					saved_flow[s]  = c.flow;
				end
			end
			CMD_TRIM_VALVE: begin
				if (c.phase == PH_NONE) begin
					// no phase: expiration valve passed through, not clamped
					r.value = saved_valve[0];
				end else begin
					err  = int'(c.flow) - int'(saved_flow[s]);
					quo  = err / 1000;
					amag = (quo < 0) ? -quo : quo;
					v    = saved_valve[s];
					if (amag == 0)
						v = v;
					else if (amag == 1)
						v += (quo > 0) ? -3 : 2;
					else if (amag == 2)
						v += (quo > 0) ? -5 : 3;
					else if (amag == 4)
						v += (quo > 0) ? -7 : 3;
					else if (amag == 8)
						v += (quo > 0) ? -11 : 5;
					else
						v += (quo > 0) ? -13 : 5;
					r.value = limit_to(v, lim_valve_min, lim_valve_max);
				end
			end
			CMD_SAVE_SPEED: begin
				if (c.phase != PH_NONE) begin
					saved_speed[s] = c.setting;
					saved_press[s] = c.press;
				end
			end
			CMD_TRIM_SPEED: begin
				if (c.phase == PH_NONE) begin
					r.value = saved_speed[0];
				end else begin
					err  = int'(c.press) - int'(saved_press[s]);
					amag = (err < 0) ? -err : err;
					v    = saved_speed[s];
					if (amag < 20)
						v = v;
					else if (amag < 30)
						v += err * 3;
					else if (amag < 40)
						v += err * 10;
					else
						v += (err < 0) ? -500 : 500;
					r.value = limit_to(v, lim_speed_min, lim_speed_max);
				end
			end
			CMD_PRELOAD: begin
				saved_press[0] = c.press;
				saved_press[1] = c.peak;
			end
			default: ;
		endcase
		r.ready = (saved_press[0] != 0) && (saved_flow[0] != 0);
		return r;
	endfunction

	// add one command request to the backlog and track the slots it aims at
	task automatic queue_cmd(input logic [2:0] cmd, input phase_t ph, input int setting,
		input int flow, input int press, input int peak);
		vent_cmd_t c;
		int s;
		c.cmd     = cmd;
		c.phase   = ph;
		c.setting = setting_t'(setting);
		c.flow    = flow_t'(flow);
		c.press   = press_t'(press);
		c.peak    = press_t'(peak);
		s = (ph == PH_EXP) ? 0 : 1;
		if (cmd == CMD_SAVE_VALVE && ph != PH_NONE)
			plan_flow[s] = int'(c.flow);
		if (cmd == CMD_SAVE_SPEED && ph != PH_NONE)
			plan_press[s] = int'(c.press);
		if (cmd == CMD_PRELOAD) begin
			plan_press[0] = int'(c.press);
			plan_press[1] = int'(c.peak);
		end
		cmd_backlog.push_back(c);
	endtask

	// random command, mostly saves and trims aimed at the band and table edges
	task automatic queue_random();
		int r, s, off, setting, flow, press, peak, lo, hi;
		logic [2:0] cmd;
		phase_t ph;
		r = $urandom_range(99);
		if (r < 20)
			cmd = CMD_SAVE_VALVE;
		else if (r < 45)
			cmd = CMD_TRIM_VALVE;
		else if (r < 65)
			cmd = CMD_SAVE_SPEED;
		else if (r < 90)
			cmd = CMD_TRIM_SPEED;
		else if (r < 95)
			cmd = CMD_PRELOAD;
		else
			cmd = CMD_SPARE_A + 3'($urandom_range(2));
		ph = ($urandom_range(9) == 0) ? PH_NONE : phase_t'(1 + $urandom_range(2));
		s  = (ph == PH_EXP) ? 0 : 1;

		// setting near zero, full scale, or the active limits, else fully random
		lo = (cmd == CMD_SAVE_SPEED) ? lim_speed_min : lim_valve_min;
		hi = (cmd == CMD_SAVE_SPEED) ? lim_speed_max : lim_valve_max;
		case ($urandom_range(5))
			0: setting = $urandom_range(15);
			1: setting = 65535 - $urandom_range(15);
			2: setting = lo + $urandom_range(30) - 15;
			3: setting = hi + $urandom_range(30) - 15;
			default: setting = $urandom;
		endcase

		// flow error spread over the quotient table and its boundaries
		case ($urandom_range(4))
			0: off = 1000 * int'($urandom_range(10)) + int'($urandom_range(999));
			1: off = 1000 * int'($urandom_range(10)) + ($urandom_range(1) ? 999 : 0);
			2: off = int'($urandom_range(3000));
			default: off = int'($urandom_range(32'h1FFFFF));
		endcase
		if ($urandom_range(1))
			off = -off;
		if (cmd == CMD_TRIM_VALVE)
			flow = plan_flow[s] + off;
		else
			flow = ($urandom_range(5) == 0) ? 0 : int'($urandom);

		// pressure error around the speed bands
		if (cmd == CMD_TRIM_SPEED) begin
			off = ($urandom_range(3) == 0) ? int'($urandom_range(65535)) : int'($urandom_range(45));
			if ($urandom_range(1))
				off = -off;
			press = plan_press[s] + off;
		end else begin
			press = ($urandom_range(5) == 0) ? 0 : int'($urandom);
		end
		peak = ($urandom_range(7) == 0) ? 0 : int'($urandom);
		queue_cmd(cmd, ph, setting, flow, press, peak);
	endtask

	task automatic queue_random_run(input int n);
		@(negedge clk);
		repeat (n)
			queue_random();
	endtask

	// wait until every request is taken and every result is back
	task automatic drain();
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || s_tvalid || pending_trims.size() != 0);
	endtask

	task automatic write_limit(input reg_idx_t idx, input setting_t val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_VALVE_MIN: lim_valve_min = val;
			REG_VALVE_MAX: lim_valve_max = val;
			REG_SPEED_MIN: lim_speed_min = val;
			default:       lim_speed_max = val;
		endcase
	endtask

	// limits change only with the block idle
	task automatic set_limits(input int vmin, input int vmax, input int smin, input int smax);
		drain();
		write_limit(REG_VALVE_MIN, setting_t'(vmin));
		write_limit(REG_VALVE_MAX, setting_t'(vmax));
		write_limit(REG_SPEED_MIN, setting_t'(smin));
		write_limit(REG_SPEED_MAX, setting_t'(smax));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender: offers the backlog with random gaps, predicts on every accepted request
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				pending_trims.push_back(apply_command(offered));
				cmds_taken++;
			end
			if (!s_tvalid || s_tready) begin
				// gap-free stretch in the middle of the run
				if (cmd_backlog.size() != 0 && ((cmds_taken >= 450 && cmds_taken < 650)
					|| $urandom_range(99) >= 21)) begin
					offered = cmd_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {3'b000, offered.peak, offered.press, offered.flow,
						offered.setting};
					s_tuser  <= {offered.phase, offered.cmd};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result against the oldest prediction, stalls at random
	always @(posedge clk) begin
		trim_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_trims.size() == 0) begin
					$error("result with no request waiting: result_value %0d, data_ready %0d",
						m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = pending_trims.pop_front();
					if (m_tdata !== want.value) begin
						$error("result_value: expected %0d, actual %0d", want.value, m_tdata);
						mismatches++;
					end
					if (m_tuser !== want.ready) begin
						$error("data_ready: expected %0d, actual %0d", want.ready, m_tuser);
						mismatches++;
					end
				end
				results_taken++;
				// long hold-off so the block fills and backs up the sender
				if (results_taken == HOLD_AT_RESULT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (results_taken >= 650 && results_taken < 850)
					|| $urandom_range(99) >= 21;
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** breath_phase_valve_blower_trim: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part with the limits at their reset values
		@(negedge clk);
		queue_cmd(CMD_TRIM_VALVE, PH_NONE, 0, 0, 0, 0);
		queue_cmd(CMD_SAVE_VALVE, PH_EXP, 65535, 1048575, 0, 0);
		// huge negative error: step up past full scale, saturates high
		queue_cmd(CMD_TRIM_VALVE, PH_EXP, 0, -1048576, 0, 0);
		queue_cmd(CMD_SAVE_VALVE, PH_INSP, 0, -1048576, 0, 0);
		// step down from zero goes negative before the clamp
		queue_cmd(CMD_TRIM_VALVE, PH_PLATEAU, 0, 1048575, 0, 0);
		queue_cmd(CMD_SAVE_VALVE, PH_PLATEAU, 1000, 0, 0, 0);
		// walk through the valve step table
		queue_cmd(CMD_TRIM_VALVE, PH_INSP, 0, 1000, 0, 0);
		queue_cmd(CMD_TRIM_VALVE, PH_INSP, 0, -1999, 0, 0);
		queue_cmd(CMD_TRIM_VALVE, PH_INSP, 0, 2500, 0, 0);
		queue_cmd(CMD_TRIM_VALVE, PH_PLATEAU, 0, 3000, 0, 0);
		queue_cmd(CMD_TRIM_VALVE, PH_INSP, 0, 4999, 0, 0);
		queue_cmd(CMD_TRIM_VALVE, PH_INSP, 0, -8000, 0, 0);
		queue_cmd(CMD_TRIM_VALVE, PH_INSP, 0, -999, 0, 0);
		// save with no phase stores nothing
		queue_cmd(CMD_SAVE_VALVE, PH_NONE, 12345, 777, 0, 0);
		queue_cmd(CMD_SAVE_SPEED, PH_EXP, 30000, 0, 0, 0);
		queue_cmd(CMD_PRELOAD, PH_NONE, 0, 0, 32767, -32768);
		queue_cmd(CMD_TRIM_SPEED, PH_EXP, 0, 0, -32768, 0);
		queue_cmd(CMD_SAVE_SPEED, PH_INSP, 100, 0, 100, 0);
		// speed bands and their edges
		queue_cmd(CMD_TRIM_SPEED, PH_INSP, 0, 0, 120, 0);
		queue_cmd(CMD_TRIM_SPEED, PH_PLATEAU, 0, 0, 139, 0);
		queue_cmd(CMD_TRIM_SPEED, PH_INSP, 0, 0, 81, 0);
		queue_cmd(CMD_TRIM_SPEED, PH_INSP, 0, 0, 60, 0);
		queue_cmd(CMD_TRIM_SPEED, PH_NONE, 0, 0, 0, 0);
		queue_cmd(CMD_SAVE_SPEED, PH_NONE, 999, 0, 5, 0);
		queue_cmd(CMD_SPARE_A, PH_EXP, 65535, -1, -1, -1);
		queue_cmd(CMD_SPARE_B, PH_INSP, 65535, -1, -1, -1);
		queue_cmd(CMD_SPARE_C, PH_PLATEAU, 65535, -1, -1, -1);

		// random part over several limit settings
		set_limits(200, 60000, 500, 50000);
		queue_random_run(RAND_PER_SETTING);
		// speed pinned at full scale, valve full range
		set_limits(0, 65535, 65535, 65535);
		queue_random_run(RAND_PER_SETTING);
		// minimum above maximum, both pairs
		set_limits(50000, 1000, 40000, 20000);
		queue_random_run(RAND_PER_SETTING);
		// everything pinned at zero
		set_limits(0, 0, 0, 0);
		queue_random_run(RAND_PER_SETTING);
		set_limits($urandom_range(30000), $urandom_range(65535, 30000),
			$urandom_range(30000), $urandom_range(65535, 30000));
		queue_random_run(RAND_PER_SETTING);
		set_limits($urandom_range(65535), $urandom_range(65535),
			$urandom_range(65535), $urandom_range(65535));
		queue_random_run(RAND_PER_SETTING);
		set_limits(0, 65535, 0, 65535);
		queue_random_run(RAND_PER_SETTING);

		drain();
		// let the two-stage pipe settle in case of a stray result
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_trims.size() == 0)
			$display("** breath_phase_valve_blower_trim: PASSED **");
		else
			$display("** breath_phase_valve_blower_trim: FAILED **");
		$finish;
	end

endmodule
